>>> hdl/sobel_edge_magnitude_top_defines.svh
// assertion macros for the sobel edge magnitude block
`ifndef SOBEL_EDGE_MAGNITUDE_TOP_DEFINES_SVH
`define SOBEL_EDGE_MAGNITUDE_TOP_DEFINES_SVH

// same-cycle implication, checked on clk while out of reset
`define SEM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk while out of reset
`define SEM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/sem_pkg.sv
// shared constants, types and the luma function for the sobel edge block
`timescale 1ns / 1ps

package sem_pkg;

  localparam int MaxWidth  = 2048;
  localparam int MaxHeight = 4096;

  localparam int ColW     = $clog2(MaxWidth);
  localparam int RowW     = $clog2(MaxHeight);
  localparam int FwW      = 12;
  localparam int FhW      = 13;
  localparam int CfgDataW = 13;
  localparam int CfgIdxW  = 1;
  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  localparam logic [CfgIdxW-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [FwW-1:0] FwReset = 12'd640;
  localparam logic [FhW-1:0] FhReset = 13'd480;
  localparam logic [FwW-1:0] FwMax   = FwW'(MaxWidth);
  localparam logic [FhW-1:0] FhMax   = FhW'(MaxHeight);

  // unsigned q0.16 luma weights, they sum to 65536
  localparam logic [15:0] LumaR = 16'd19595;
  localparam logic [15:0] LumaG = 16'd38470;
  localparam logic [15:0] LumaB = 16'd7471;

  typedef struct packed {
    logic [ColW-1:0] col;
    logic [RowW-1:0] row;
    logic [7:0]      level;
    logic            last;
  } sem_result_t;

  typedef struct packed {
    logic [ColW-1:0] col;
    logic [RowW-1:0] row;
    logic            interior;
    logic            border;
  } sem_pos_t;

  typedef struct packed {
    logic [1:0]  count;
    sem_result_t first;
    sem_result_t second;
  } sem_push_t;

  function automatic logic [7:0] luma(input logic [7:0] red,
                                      input logic [7:0] green,
                                      input logic [7:0] blue);
    logic [23:0] acc;
    acc = 24'(LumaR) * 24'(red) + 24'(LumaG) * 24'(green) + 24'(LumaB) * 24'(blue);
    return acc[23:16];
  endfunction

endpackage

>>> hdl/sem_line_buf.sv
// two gray line memories holding the previous two rows
`timescale 1ns / 1ps

module sem_line_buf (
  input  logic                    clk,
  input  logic                    rd_en,
  input  logic [sem_pkg::ColW-1:0] rd_addr,
  input  logic                    wr_en,
  input  logic [sem_pkg::ColW-1:0] wr_addr,
  input  logic [7:0]              wr_top,
  input  logic [7:0]              wr_mid,
  output logic [7:0]              rd_top,
  output logic [7:0]              rd_mid
);

  // top_mem holds row r-2, mid_mem holds row r-1
  logic [7:0] top_mem [0:sem_pkg::MaxWidth-1];
  logic [7:0] mid_mem [0:sem_pkg::MaxWidth-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      top_mem[wr_addr] <= wr_top;
      mid_mem[wr_addr] <= wr_mid;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_top <= top_mem[rd_addr];
      rd_mid <= mid_mem[rd_addr];
    end
  end

endmodule

>>> hdl/sem_sobel_core.sv
// 3x3 window columns and the l1 sobel gradient
`timescale 1ns / 1ps

module sem_sobel_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       shift_en,
  input  logic [7:0] top,
  input  logic [7:0] mid,
  input  logic [7:0] bot,
  output logic [7:0] level
);

  // entries 0..2 column c-2, 3..5 column c-1, each top, middle, bottom
  logic [7:0] win_r [0:5];

  logic [9:0]  right_sum;
  logic [9:0]  left_sum;
  logic [9:0]  lower_sum;
  logic [9:0]  upper_sum;
  logic [9:0]  abs_x;
  logic [9:0]  abs_y;
  logic [10:0] mag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= 8'd0;
      end
    end else if (shift_en) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= top;
      win_r[4] <= mid;
      win_r[5] <= bot;
    end
  end

  always_comb begin
    right_sum = {2'b00, top} + {1'b0, mid, 1'b0} + {2'b00, bot};
    left_sum  = {2'b00, win_r[0]} + {1'b0, win_r[1], 1'b0} + {2'b00, win_r[2]};
    lower_sum = {2'b00, win_r[2]} + {1'b0, win_r[5], 1'b0} + {2'b00, bot};
    upper_sum = {2'b00, win_r[0]} + {1'b0, win_r[3], 1'b0} + {2'b00, top};
    abs_x = (right_sum >= left_sum) ? right_sum - left_sum : left_sum - right_sum;
    abs_y = (lower_sum >= upper_sum) ? lower_sum - upper_sum : upper_sum - lower_sum;
    mag   = {1'b0, abs_x} + {1'b0, abs_y};
    level = (mag > 11'd255) ? 8'hFF : mag[7:0];
  end

endmodule

>>> hdl/sem_out_fifo.sv
// small result queue taking up to two words per cycle
`timescale 1ns / 1ps

module sem_out_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  sem_pkg::sem_push_t  push,
  input  logic                pop,
  output logic                room,
  output logic                out_valid,
  output sem_pkg::sem_result_t out_item
);

  sem_pkg::sem_result_t             fifo_r [0:sem_pkg::FifoDepth-1];
  logic [sem_pkg::FifoPtrW-1:0]     wr_ptr_r;
  logic [sem_pkg::FifoPtrW-1:0]     wr_ptr_nxt;
  logic [sem_pkg::FifoPtrW-1:0]     rd_ptr_r;
  logic [sem_pkg::FifoPtrW-1:0]     rd_ptr_nxt;
  logic [sem_pkg::FifoCntW-1:0]     count_r;
  logic [sem_pkg::FifoCntW-1:0]     count_nxt;
  logic [sem_pkg::FifoPtrW-1:0]     wr_ptr_plus;

  assign wr_ptr_plus = wr_ptr_r + 1'b1;

  // room for a full two-word push whatever the consumer does
  assign room      = count_r <= sem_pkg::FifoCntW'(sem_pkg::FifoDepth - 2);
  assign out_valid = count_r != '0;
  assign out_item  = fifo_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + sem_pkg::FifoPtrW'(push.count);
    rd_ptr_nxt = rd_ptr_r + sem_pkg::FifoPtrW'(pop);
    count_nxt  = count_r + sem_pkg::FifoCntW'(push.count) - sem_pkg::FifoCntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      fifo_r[wr_ptr_r] <= push.first;
    end
    if (push.count == 2'd2) begin
      fifo_r[wr_ptr_plus] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> hdl/sobel_edge_magnitude_top.sv
// a pixel's first word is offered after stage a, stage b and the result queue
// throughput: one pixel per cycle while in_stall stays low; a pixel that makes
//   two words sends them one at a time over the single-word result port
// line memories read at accept and written two stages later, no clear pass
// reset (synchronous, active low): 640x480 frame, counters and window zero
`timescale 1ns / 1ps

`include "sobel_edge_magnitude_top_defines.svh"

module sobel_edge_magnitude_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   in_red,
  input  logic [7:0]                   in_green,
  input  logic [7:0]                   in_blue,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [sem_pkg::ColW-1:0]     out_col,
  output logic [sem_pkg::RowW-1:0]     out_row,
  output logic [7:0]                   out_edge_level,
  output logic                         out_last_of_run,
  input  logic                         cfg_we,
  input  logic [sem_pkg::CfgIdxW-1:0]  cfg_idx,
  input  logic [sem_pkg::CfgDataW-1:0] cfg_wdata
);

  logic [sem_pkg::FwW-1:0]  eff_w_r;
  logic [sem_pkg::FhW-1:0]  eff_h_r;
  logic [sem_pkg::FwW-1:0]  cfg_w_clamp;
  logic [sem_pkg::FhW-1:0]  cfg_h_clamp;
  logic [sem_pkg::ColW-1:0] col_count_r;
  logic [sem_pkg::ColW-1:0] col_count_nxt;
  logic [sem_pkg::RowW-1:0] row_count_r;
  logic [sem_pkg::RowW-1:0] row_count_nxt;
  logic [sem_pkg::FwW-1:0]  col_ext;
  logic [sem_pkg::FhW-1:0]  row_ext;
  logic                     col_last;
  logic                     row_last;
  logic                     col_in_range;

  logic                     accept;
  logic                     a_valid_r;
  logic                     a_adv;
  logic [7:0]               a_red_r;
  logic [7:0]               a_green_r;
  logic [7:0]               a_blue_r;
  sem_pkg::sem_pos_t        a_pos_r;
  sem_pkg::sem_pos_t        in_pos;
  logic [7:0]               a_top;
  logic [7:0]               a_mid;

  logic                     b_valid_r;
  logic                     b_adv;
  sem_pkg::sem_pos_t        b_pos_r;
  logic [7:0]               b_gray_r;
  logic [7:0]               b_top_r;
  logic [7:0]               b_mid_r;
  logic [7:0]               b_level;

  sem_pkg::sem_result_t     inner_word;
  sem_pkg::sem_result_t     edge_word;
  sem_pkg::sem_push_t       push;
  sem_pkg::sem_result_t     head;
  logic                     fifo_room;
  logic                     pop;

  // ---------------- configuration and position counters
  always_comb begin
    cfg_w_clamp = cfg_wdata[sem_pkg::FwW-1:0];
    if (cfg_w_clamp == '0) begin
      cfg_w_clamp = sem_pkg::FwW'(1);
    end else if (cfg_w_clamp > sem_pkg::FwMax) begin
      cfg_w_clamp = sem_pkg::FwMax;
    end
    cfg_h_clamp = cfg_wdata[sem_pkg::FhW-1:0];
    if (cfg_h_clamp == '0) begin
      cfg_h_clamp = sem_pkg::FhW'(1);
    end else if (cfg_h_clamp > sem_pkg::FhMax) begin
      cfg_h_clamp = sem_pkg::FhMax;
    end
  end

  assign col_ext      = {1'b0, col_count_r};
  assign row_ext      = {1'b0, row_count_r};
  assign col_last     = col_ext == eff_w_r - 1'b1;
  assign row_last     = row_ext == eff_h_r - 1'b1;
  assign col_in_range = col_ext < eff_w_r;

  always_comb begin
    col_count_nxt = col_count_r;
    row_count_nxt = row_count_r;
    if (accept) begin
      if (col_last) begin
        col_count_nxt = '0;
        row_count_nxt = row_last ? '0 : row_count_r + 1'b1;
      end else begin
        col_count_nxt = col_count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_w_r     <= sem_pkg::FwReset;
      eff_h_r     <= sem_pkg::FhReset;
      col_count_r <= '0;
      row_count_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        sem_pkg::REG_FRAME_WIDTH:  eff_w_r <= cfg_w_clamp;
        sem_pkg::REG_FRAME_HEIGHT: eff_h_r <= cfg_h_clamp;
        default: ;
      endcase
      // a register write restarts the frame
      col_count_r <= '0;
      row_count_r <= '0;
    end else begin
      col_count_r <= col_count_nxt;
      row_count_r <= row_count_nxt;
    end
  end

  // ---------------- pipeline control
  assign pop      = out_valid & ~out_stall;
  assign b_adv    = b_valid_r & fifo_room;
  assign a_adv    = a_valid_r & (~b_valid_r | b_adv);
  assign in_stall = a_valid_r & ~a_adv;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    in_pos.col      = col_count_r;
    in_pos.row      = row_count_r;
    in_pos.interior = (col_count_r >= sem_pkg::ColW'(2)) && (row_count_r >= sem_pkg::RowW'(2));
    in_pos.border   = (col_count_r == '0) || col_last || (row_count_r == '0) || row_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        a_valid_r <= 1'b1;
      end else if (a_adv) begin
        a_valid_r <= 1'b0;
      end
      if (a_adv) begin
        b_valid_r <= 1'b1;
      end else if (b_adv) begin
        b_valid_r <= 1'b0;
      end
    end
  end

  // stage a: pixel and line reads; stage b: gray and neighbors
  always_ff @(posedge clk) begin
    if (accept) begin
      a_red_r   <= in_red;
      a_green_r <= in_green;
      a_blue_r  <= in_blue;
      a_pos_r   <= in_pos;
    end
    if (a_adv) begin
      b_pos_r  <= a_pos_r;
      b_gray_r <= sem_pkg::luma(a_red_r, a_green_r, a_blue_r);
      b_top_r  <= a_top;
      b_mid_r  <= a_mid;
    end
  end

  sem_line_buf u_line_buf (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_count_r),
    .wr_en   (b_adv),
    .wr_addr (b_pos_r.col),
    .wr_top  (b_mid_r),
    .wr_mid  (b_gray_r),
    .rd_top  (a_top),
    .rd_mid  (a_mid)
  );

  sem_sobel_core u_sobel_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (b_adv),
    .top      (b_top_r),
    .mid      (b_mid_r),
    .bot      (b_gray_r),
    .level    (b_level)
  );

  // interior word for the upper-left neighbor comes before the border word
  always_comb begin
    inner_word.col   = b_pos_r.col - 1'b1;
    inner_word.row   = b_pos_r.row - 1'b1;
    inner_word.level = b_level;
    inner_word.last  = ~b_pos_r.border;
    edge_word.col    = b_pos_r.col;
    edge_word.row    = b_pos_r.row;
    edge_word.level  = 8'd0;
    edge_word.last   = 1'b1;
    push.first  = b_pos_r.interior ? inner_word : edge_word;
    push.second = edge_word;
    if (!b_adv) begin
      push.count = 2'd0;
    end else begin
      push.count = 2'(b_pos_r.interior) + 2'(b_pos_r.border);
    end
  end

  sem_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (pop),
    .room      (fifo_room),
    .out_valid (out_valid),
    .out_item  (head)
  );

  assign out_col         = head.col;
  assign out_row         = head.row;
  assign out_edge_level  = head.level;
  assign out_last_of_run = head.last;

  // ---------------- checks
  `SEM_ASSERT_IMPL(a_col_in_frame, 1'b1, col_in_range, "column counter outside frame width")
  `SEM_ASSERT_NEXT(a_frame_wrap, accept && col_last && row_last && !cfg_we,
                   col_count_r == '0 && row_count_r == '0, "frame end did not wrap counters")
  `SEM_ASSERT_NEXT(a_b_hold, b_valid_r && !fifo_room && !a_adv,
                   b_valid_r && $stable(b_pos_r), "stage b lost a pixel while blocked")

endmodule

>>> test/sobel_edge_magnitude_top_tb.sv
// self-checking testbench for the sobel edge magnitude block: pixels in, edge words checked
`timescale 1ns / 1ps

module sobel_edge_magnitude_top_tb;

  localparam int CycleLimit  = 1000000;
  localparam int DrainCycles = 8;
  localparam int MaxReports  = 10;

  logic                         clk;
  logic                         rst_n     = 1'b0;
  logic                         in_valid  = 1'b0;
  logic                         in_stall;
  logic [7:0]                   in_red    = '0;
  logic [7:0]                   in_green  = '0;
  logic [7:0]                   in_blue   = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [sem_pkg::ColW-1:0]     out_col;
  logic [sem_pkg::RowW-1:0]     out_row;
  logic [7:0]                   out_edge_level;
  logic                         out_last_of_run;
  logic                         cfg_we    = 1'b0;
  logic [sem_pkg::CfgIdxW-1:0]  cfg_idx   = sem_pkg::REG_FRAME_WIDTH;
  logic [sem_pkg::CfgDataW-1:0] cfg_wdata = '0;

  // predictor state: raw registers, gray lines, window and raster position
  logic [sem_pkg::FwW-1:0] frame_w_reg = 12'd640;
  logic [sem_pkg::FhW-1:0] frame_h_reg = 13'd480;
  bit [7:0]       gray_up1 [0:sem_pkg::MaxWidth-1];
  bit [7:0]       gray_up2 [0:sem_pkg::MaxWidth-1];
  bit [7:0]       win [0:5];
  int unsigned    cur_col = 0;
  int unsigned    cur_row = 0;

  sem_pkg::sem_result_t pending_levels[$];

  int unsigned mismatches    = 0;
  int unsigned words_checked = 0;
  int unsigned pixels_sent   = 0;
  int unsigned geometries    = 0;
  int unsigned cycle_count   = 0;

  // sender burst shaping and receiver stall pattern
  int unsigned gap_max       = 0;
  int unsigned burst_left    = 0;
  int unsigned stall_pct     = 0;
  int unsigned hold_req      = 0;
  int unsigned hold_tag      = 0;
  int unsigned hold_tag_seen = 0;
  int unsigned hold_left     = 0;

  sobel_edge_magnitude_top u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_col         (out_col),
    .out_row         (out_row),
    .out_edge_level  (out_edge_level),
    .out_last_of_run (out_last_of_run),
    .cfg_we          (cfg_we),
    .cfg_idx         (cfg_idx),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d words still outstanding", cycle_count,
               pending_levels.size());
      $display("sobel_edge_magnitude_top_tb: FAIL");
      $finish;
    end
  end

  // receiver: long hold-off on request, otherwise random stalls at stall_pct
  always @(posedge clk) begin
    if (hold_tag != hold_tag_seen) begin
      hold_tag_seen = hold_tag;
      hold_left     = hold_req;
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    sem_pkg::sem_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_levels.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t: unexpected word col %0d row %0d level %0d last %0b", $time,
                   out_col, out_row, out_edge_level, out_last_of_run);
      end else begin
        want = pending_levels.pop_front();
        words_checked++;
        if (out_col !== want.col || out_row !== want.row ||
            out_edge_level !== want.level || out_last_of_run !== want.last) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("%0t: expected col %0d row %0d level %0d last %0b, got %0d %0d %0d %0b",
                     $time, want.col, want.row, want.level, want.last,
                     out_col, out_row, out_edge_level, out_last_of_run);
        end
      end
    end
  end

  // zero acts as one, anything above the maximum acts as the maximum
  function automatic int unsigned active_width();
    if (frame_w_reg == 0) return 1;
    if (frame_w_reg > sem_pkg::MaxWidth) return sem_pkg::MaxWidth;
    return frame_w_reg;
  endfunction

  function automatic int unsigned active_height();
    if (frame_h_reg == 0) return 1;
    if (frame_h_reg > sem_pkg::MaxHeight) return sem_pkg::MaxHeight;
    return frame_h_reg;
  endfunction

  task automatic predict_sobel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    int unsigned wd;
    int unsigned ht;
    logic [23:0] acc;
    logic [7:0]  gray;
    logic [7:0]  top;
    logic [7:0]  mid;
    int          gx;
    int          gy;
    int          mag;
    bit          border;
    sem_pkg::sem_result_t res;
    wd = active_width();
    ht = active_height();
    acc = 24'd19595 * r + 24'd38470 * g + 24'd7471 * b;
    gray = acc[23:16];
    top = gray_up2[cur_col];
    mid = gray_up1[cur_col];
    border = (cur_col == 0) || (cur_col == wd - 1) || (cur_row == 0) || (cur_row == ht - 1);
    // the interior pixel up-left of this one is now complete
    if (cur_col >= 2 && cur_row >= 2) begin
      gx = (int'(top) + 2 * int'(mid) + int'(gray))
         - (int'(win[0]) + 2 * int'(win[1]) + int'(win[2]));
      gy = (int'(win[2]) + 2 * int'(win[5]) + int'(gray))
         - (int'(win[0]) + 2 * int'(win[3]) + int'(top));
      mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
      if (mag > 255) mag = 255;
      res.col   = sem_pkg::ColW'(cur_col - 1);
      res.row   = sem_pkg::RowW'(cur_row - 1);
      res.level = 8'(mag);
      res.last  = !border;
      pending_levels.push_back(res);
    end
    if (border) begin
      res.col   = sem_pkg::ColW'(cur_col);
      res.row   = sem_pkg::RowW'(cur_row);
      res.level = 8'd0;
      res.last  = 1'b1;
      pending_levels.push_back(res);
    end
    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = top;
    win[4] = mid;
    win[5] = gray;
    gray_up2[cur_col] = mid;
    gray_up1[cur_col] = gray;
    if (cur_col + 1 >= wd) begin
      cur_col = 0;
      cur_row = (cur_row + 1 >= ht) ? 0 : cur_row + 1;
    end else begin
      cur_col++;
    end
  endtask

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (gap_max != 0) begin
        gap = $urandom_range(1, gap_max);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predict_sobel(r, g, b);
    pixels_sent++;
  endtask

  task automatic send_noise(input int unsigned count);
    logic [23:0] rgb;
    repeat (count) begin
      rgb = 24'($urandom);
      send_pixel(rgb[23:16], rgb[15:8], rgb[7:0]);
    end
  endtask

  // wait for every outstanding word, then let a word-less pixel finish too
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [sem_pkg::CfgIdxW-1:0] idx,
                           input logic [sem_pkg::CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    if (idx == sem_pkg::REG_FRAME_WIDTH) frame_w_reg = data[sem_pkg::FwW-1:0];
    else frame_h_reg = data[sem_pkg::FhW-1:0];
    cur_col = 0;
    cur_row = 0;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_frame(input logic [sem_pkg::CfgDataW-1:0] w,
                           input logic [sem_pkg::CfgDataW-1:0] h);
    drain_pipeline();
    write_reg(sem_pkg::REG_FRAME_WIDTH, w);
    write_reg(sem_pkg::REG_FRAME_HEIGHT, h);
    geometries++;
  endtask

  // 640x480 out of reset: first row wraps after 640 pixels
  task automatic test_reset_geometry();
    stall_pct = 20;
    gap_max   = 3;
    geometries++;
    send_noise(642);
  endtask

  task automatic test_directed_patterns();
    logic [23:0] pix [0:15];
    int k;
    pix = '{24'h000000, 24'h000000, 24'hFFFFFF, 24'hFFFFFF,
            24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFFFF,
            24'h000000, 24'h000000, 24'hFFFFFF, 24'hFFFFFF,
            24'h808080, 24'h7F7F7F, 24'h010101, 24'hFEFEFE};
    stall_pct = 30;
    gap_max   = 2;
    // strong vertical step saturates, primaries exercise each luma weight
    set_frame(13'd4, 13'd4);
    for (k = 0; k < 16; k++) send_pixel(pix[k][23:16], pix[k][15:8], pix[k][7:0]);
    // narrow frame: every pixel is border
    set_frame(13'd2, 13'd2);
    for (k = 0; k < 4; k++) send_pixel(pix[k + 4][23:16], pix[k + 4][15:8], pix[k + 4][7:0]);
  endtask

  task automatic test_frame_restart();
    stall_pct = 40;
    gap_max   = 4;
    // bit 12 of the width word falls outside the register
    set_frame(13'h1005, 13'd5);
    send_noise(8);
    drain_pipeline();
    write_reg(sem_pkg::REG_FRAME_HEIGHT, 13'd5);
    // two frames back to back, counters wrap on their own
    send_noise(50);
  endtask

  task automatic test_backpressure();
    set_frame(13'd8, 13'd6);
    stall_pct = 0;
    gap_max   = 0;
    hold_req  = 400;
    hold_tag++;
    send_noise(96);
  endtask

  task automatic test_size_limits();
    stall_pct = 10;
    gap_max   = 2;
    // width 0 acts as 1, oversized height register is clamped
    set_frame(13'd0, 13'h1FFF);
    send_noise(40);
    // oversized width register is clamped
    set_frame(13'h0FFF, 13'd3);
    send_noise(40);
  endtask

  task automatic test_random_frames(input int unsigned budget);
    int unsigned sent;
    int unsigned total;
    int unsigned mode;
    int unsigned base;
    logic [sem_pkg::CfgDataW-1:0] w;
    logic [sem_pkg::CfgDataW-1:0] h;
    logic [23:0] rgb;
    sent = 0;
    while (sent < budget) begin
      case ($urandom_range(9))
        0:       w = sem_pkg::CfgDataW'($urandom_range(0, 2));
        1:       w = sem_pkg::CfgDataW'($urandom_range(17, 48));
        default: w = sem_pkg::CfgDataW'($urandom_range(3, 12));
      endcase
      if ($urandom_range(7) == 0) h = sem_pkg::CfgDataW'($urandom_range(0, 2));
      else h = sem_pkg::CfgDataW'($urandom_range(3, 9));
      set_frame(w, h);
      total = active_width() * active_height() * $urandom_range(1, 3);
      // a cut frame is restarted by the next register write
      if ($urandom_range(5) == 0) total = $urandom_range(1, total);
      if (total > budget - sent) total = budget - sent;
      case ($urandom_range(3))
        0:       stall_pct = 0;
        1:       stall_pct = 25;
        2:       stall_pct = 50;
        default: stall_pct = 70;
      endcase
      case ($urandom_range(2))
        0:       gap_max = 0;
        1:       gap_max = 3;
        default: gap_max = 10;
      endcase
      if ($urandom_range(7) == 0) begin
        hold_req = $urandom_range(40, 200);
        hold_tag++;
      end
      mode = $urandom_range(2);
      base = $urandom_range(200);
      repeat (total) begin
        rgb = 24'($urandom);
        case (mode)
          0: ;
          1: rgb = {{8{rgb[0]}}, {8{rgb[1]}}, {8{rgb[2]}}};
          default: rgb = {8'(base + rgb[2:0]), 8'(base + rgb[10:8]), 8'(base + rgb[18:16])};
        endcase
        send_pixel(rgb[23:16], rgb[15:8], rgb[7:0]);
      end
      sent += total;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_geometry();
    test_directed_patterns();
    test_frame_restart();
    test_backpressure();
    test_size_limits();
    test_random_frames(950);
    drain_pipeline();
    repeat (20) @(posedge clk);
    $display("%0d pixels over %0d frame geometries (narrow, clamped, restarted, held off)",
             pixels_sent, geometries);
    $display("%0d edge words checked, %0d mismatches", words_checked, mismatches);
    if (mismatches == 0) begin
      $display("sobel_edge_magnitude_top_tb: PASS");
    end else begin
      $display("sobel_edge_magnitude_top_tb: FAIL");
    end
    $finish;
  end

endmodule
